// ===== rtl/append_then_insertion_sort_unit_assert.svh =====
// Assertion macros for the sort unit datapath.
// Needs clk and rst_n in the scope of each use; no other dependencies.
`ifndef APPEND_THEN_INSERTION_SORT_UNIT_ASSERT_SVH
`define APPEND_THEN_INSERTION_SORT_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define ATIS_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("atis assertion failed");
`define ATIS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("atis next-cycle assertion failed");
`else
`define ATIS_ASSERT(label, ante, cons)
`define ATIS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/atis_pkg.sv =====
// Package for the append-then-insertion-sort unit: sizes, codes, control word
// and the microcode table. No dependencies.
package atis_pkg;

  localparam int STORE_DEPTH = 32;
  localparam int IDX_W = $clog2(STORE_DEPTH);
  localparam int CNT_W = $clog2(STORE_DEPTH + 1);
  localparam int WORD_W = 32;

  typedef enum logic {
    ACT_APPEND = 1'b0,
    ACT_SORT   = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ST_DATA  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    STP_CHK   = 4'd0,
    STP_OUTER = 4'd1,
    STP_LDKEY = 4'd2,
    STP_CMP   = 4'd3,
    STP_PLACE = 4'd4,
    STP_EMIT0 = 4'd5,
    STP_EMIT  = 4'd6,
    STP_EMPTY = 4'd7,
    STP_DONE  = 4'd8
  } step_t;

  typedef enum logic [2:0] {
    CND_NONE,
    CND_ALWAYS,
    CND_CNT_ZERO,
    CND_I_GE_CNT,
    CND_STOP,
    CND_LAST
  } cond_t;

  typedef enum logic [1:0] {
    IOP_KEEP,
    IOP_ONE,
    IOP_ZERO,
    IOP_INC
  } iop_t;

  typedef enum logic [1:0] {
    POP_KEEP,
    POP_LOAD_I,
    POP_DEC
  } pop_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_SHIFT,
    WR_KEY
  } wrop_t;

  typedef enum logic [2:0] {
    RA_I,
    RA_I_M1,
    RA_I_P1,
    RA_POS_M2,
    RA_ZERO
  } rasel_t;

  typedef enum logic [1:0] {
    EM_NONE,
    EM_DATA,
    EM_EMPTY
  } emit_t;

  typedef struct packed {
    cond_t  cond;
    step_t  target;
    logic   hold;
    iop_t   i_op;
    pop_t   pos_op;
    logic   key_ld;
    wrop_t  wr_op;
    rasel_t ra_sel;
    emit_t  emit;
    logic   done;
  } ucw_t;

  typedef struct packed {
    logic cnt_zero;
    logic i_ge_cnt;
    logic stop;
    logic last;
  } flags_t;

  localparam ucw_t UC_NOP = '{
    cond: CND_NONE, target: STP_DONE, hold: 1'b0, i_op: IOP_KEEP, pos_op: POP_KEEP,
    key_ld: 1'b0, wr_op: WR_NONE, ra_sel: RA_I, emit: EM_NONE, done: 1'b0
  };

  function automatic ucw_t ucode(input step_t step);
    ucw_t w;
    w = UC_NOP;
    unique case (step)
      STP_CHK: begin
        w.cond = CND_CNT_ZERO;
        w.target = STP_EMPTY;
        w.i_op = IOP_ONE;
      end
      STP_OUTER: begin
        w.cond = CND_I_GE_CNT;
        w.target = STP_EMIT0;
        w.ra_sel = RA_I;
      end
      STP_LDKEY: begin
        w.key_ld = 1'b1;
        w.pos_op = POP_LOAD_I;
        w.ra_sel = RA_I_M1;
      end
      STP_CMP: begin
        w.cond = CND_STOP;
        w.target = STP_PLACE;
        w.hold = 1'b1;
        w.wr_op = WR_SHIFT;
        w.pos_op = POP_DEC;
        w.ra_sel = RA_POS_M2;
      end
      STP_PLACE: begin
        w.cond = CND_ALWAYS;
        w.target = STP_OUTER;
        w.wr_op = WR_KEY;
        w.i_op = IOP_INC;
      end
      STP_EMIT0: begin
        w.i_op = IOP_ZERO;
        w.ra_sel = RA_ZERO;
      end
      STP_EMIT: begin
        w.cond = CND_LAST;
        w.target = STP_DONE;
        w.hold = 1'b1;
        w.emit = EM_DATA;
        w.i_op = IOP_INC;
        w.ra_sel = RA_I_P1;
      end
      STP_EMPTY: begin
        w.cond = CND_ALWAYS;
        w.target = STP_DONE;
        w.emit = EM_EMPTY;
      end
      STP_DONE: begin
        w.done = 1'b1;
      end
      default: begin
        w.done = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/atis_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module atis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/atis_seq.sv =====
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on atis_pkg.
module atis_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            go,
  input  atis_pkg::flags_t flags,
  output atis_pkg::ucw_t  ctrl,
  output logic            take,
  output logic            running
);
  import atis_pkg::*;

  step_t step_r, step_nxt;
  logic  running_r, running_nxt;
  ucw_t  w;

  assign w = running_r ? ucode(step_r) : UC_NOP;

  always_comb begin
    unique case (w.cond)
      CND_NONE:     take = 1'b0;
      CND_ALWAYS:   take = 1'b1;
      CND_CNT_ZERO: take = flags.cnt_zero;
      CND_I_GE_CNT: take = flags.i_ge_cnt;
      CND_STOP:     take = flags.stop;
      CND_LAST:     take = flags.last;
      default:      take = 1'b0;
    endcase
  end

  always_comb begin
    step_nxt = step_r;
    running_nxt = running_r;
    if (running_r) begin
      if (w.done) begin
        running_nxt = 1'b0;
      end else if (take) begin
        step_nxt = w.target;
      end else if (!w.hold) begin
        step_nxt = step_t'(step_r + 4'd1);
      end
    end else if (go) begin
      running_nxt = 1'b1;
      step_nxt = STP_CHK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STP_CHK;
      running_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      running_r <= running_nxt;
    end
  end

  assign ctrl = w;
  assign running = running_r;

endmodule

// ===== rtl/atis_dp.sv =====
// Datapath: word store RAM, count, index, position and key registers, and
// the registered result port. Depends on atis_pkg, atis_ram and the assert header.
`include "append_then_insertion_sort_unit_assert.svh"
module atis_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            app,
  input  logic signed [atis_pkg::WORD_W-1:0] app_value,
  input  atis_pkg::ucw_t                  ctrl,
  input  logic                            take,
  output atis_pkg::flags_t                flags,
  output logic                            out_valid,
  output logic signed [atis_pkg::WORD_W-1:0] out_sorted_word,
  output logic                            out_is_last,
  output logic [1:0]                      out_status
);
  import atis_pkg::*;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic signed [WORD_W-1:0] key_r, key_nxt;
  logic signed [WORD_W-1:0] rdata;
  logic [CNT_W-1:0] ra_full;
  logic [IDX_W-1:0] waddr;
  logic [WORD_W-1:0] wdata;
  logic we;
  logic moving;
  logic app_ok, app_full;
  logic valid_r, valid_nxt;
  logic signed [WORD_W-1:0] word_r, word_nxt;
  logic last_r, last_nxt;
  status_t status_r, status_nxt;

  assign app_ok = app && (count_r < CNT_W'(STORE_DEPTH));
  assign app_full = app && !app_ok;
  assign moving = (ctrl.wr_op == WR_SHIFT) && !take;

  assign flags.cnt_zero = (count_r == '0);
  assign flags.i_ge_cnt = (i_r >= count_r);
  assign flags.stop = (pos_r == '0) || !(key_r < rdata);
  assign flags.last = (CNT_W'(i_r + 1'b1) == count_r);

  always_comb begin
    unique case (ctrl.ra_sel)
      RA_I:      ra_full = i_r;
      RA_I_M1:   ra_full = CNT_W'(i_r - 1'b1);
      RA_I_P1:   ra_full = CNT_W'(i_r + 1'b1);
      RA_POS_M2: ra_full = CNT_W'(pos_r - 2'd2);
      RA_ZERO:   ra_full = '0;
      default:   ra_full = '0;
    endcase
  end

  always_comb begin
    we = 1'b0;
    waddr = pos_r[IDX_W-1:0];
    wdata = rdata;
    if (app_ok) begin
      we = 1'b1;
      waddr = count_r[IDX_W-1:0];
      wdata = app_value;
    end else if (moving) begin
      we = 1'b1;
    end else if (ctrl.wr_op == WR_KEY) begin
      we = 1'b1;
      wdata = key_r;
    end
  end

  atis_ram #(.WIDTH(WORD_W), .DEPTH(STORE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (ra_full[IDX_W-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    count_nxt = app_ok ? CNT_W'(count_r + 1'b1) : count_r;
    unique case (ctrl.i_op)
      IOP_KEEP: i_nxt = i_r;
      IOP_ONE:  i_nxt = CNT_W'(1);
      IOP_ZERO: i_nxt = '0;
      IOP_INC:  i_nxt = CNT_W'(i_r + 1'b1);
      default:  i_nxt = i_r;
    endcase
    pos_nxt = pos_r;
    if (ctrl.pos_op == POP_LOAD_I) begin
      pos_nxt = i_r;
    end else if (ctrl.pos_op == POP_DEC && moving) begin
      pos_nxt = CNT_W'(pos_r - 1'b1);
    end
    key_nxt = ctrl.key_ld ? rdata : key_r;
  end

  always_comb begin
    valid_nxt = 1'b0;
    word_nxt = '0;
    last_nxt = 1'b1;
    status_nxt = ST_DATA;
    if (ctrl.emit == EM_DATA) begin
      valid_nxt = 1'b1;
      word_nxt = rdata;
      last_nxt = take;
    end else if (ctrl.emit == EM_EMPTY) begin
      valid_nxt = 1'b1;
      status_nxt = ST_EMPTY;
    end else if (app_full) begin
      valid_nxt = 1'b1;
      status_nxt = ST_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt;
    pos_r <= pos_nxt;
    key_r <= key_nxt;
    word_r <= word_nxt;
    last_r <= last_nxt;
    status_r <= status_nxt;
  end

  assign out_valid = valid_r;
  assign out_sorted_word = word_r;
  assign out_is_last = last_r;
  assign out_status = status_r;

  `ATIS_ASSERT(a_count_bound, 1'b1, count_r <= CNT_W'(STORE_DEPTH))
  `ATIS_ASSERT_NEXT(a_append_counts, app_ok, count_r == CNT_W'($past(count_r) + 1'b1))
  `ATIS_ASSERT(a_status_is_last, valid_r && (status_r != ST_DATA), last_r && (word_r == '0))
  `ATIS_ASSERT(a_no_write_clash, app, ctrl.wr_op == WR_NONE)

endmodule

// ===== rtl/append_then_insertion_sort_unit.sv =====
// Append-then-insertion-sort unit. A word with in_action 0 is appended in the cycle it is
// taken (busy stays low); appending to a full store of 32 words gives one overflow result
// on the next cycle. A word with in_action 1 raises busy while a microcoded sequencer runs
// a stable insertion sort over the two-port store and then streams the words out, one
// per cycle, with the last one marked. The sort makes one compare-and-shift step for
// each inversion among the stored words. Results appear on out_valid for exactly
// one cycle and cannot be held off. Depends on atis_pkg, atis_seq and atis_dp.
module append_then_insertion_sort_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_action,
  input  logic signed [atis_pkg::WORD_W-1:0] in_value,
  output logic                               out_valid,
  output logic signed [atis_pkg::WORD_W-1:0] out_sorted_word,
  output logic                               out_is_last,
  output logic [1:0]                         out_status
);
  import atis_pkg::*;

  ucw_t   ctrl;
  flags_t flags;
  logic   take;
  logic   running;
  logic   accept;

  assign accept = start && !running;

  atis_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (accept && (in_action == ACT_SORT)),
    .flags   (flags),
    .ctrl    (ctrl),
    .take    (take),
    .running (running)
  );

  atis_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .app             (accept && (in_action == ACT_APPEND)),
    .app_value       (in_value),
    .ctrl            (ctrl),
    .take            (take),
    .flags           (flags),
    .out_valid       (out_valid),
    .out_sorted_word (out_sorted_word),
    .out_is_last     (out_is_last),
    .out_status      (out_status)
  );

  assign busy = running;

endmodule
